[sv/mcwd_pkg.sv]
// ----------------------------------------------------------------------------
// mcwd_pkg
// Shared types and constants for the multi-client watchdog aggregator.
// ----------------------------------------------------------------------------
package mcwd_pkg;

    // Client ID layout: generation tag in the high nibble, slot in the low nibble
    localparam int SLOT_BITS = 4;
    localparam int TAG_BITS  = 4;
    localparam int ID_W      = SLOT_BITS + TAG_BITS;

    localparam int CI_W      = 16;
    localparam logic [CI_W-1:0] CI_RESET = 16'd40;

    localparam int MODE_W    = 2;
    localparam int STATUS_W  = 2;

    // Result packing: status, assigned_id, check_done, kick_device, system_ok
    localparam int RES_BITS  = STATUS_W + ID_W + 3;
    localparam int RES_W     = ((RES_BITS + 7) / 8) * 8;
    localparam int IN_W      = ((ID_W + 7) / 8) * 8;

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK   = 2'd0,
        MODE_REG    = 2'd1,
        MODE_DEREG  = 2'd2,
        MODE_KICK   = 2'd3
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_BAD_ID = 2'd2,
        ST_RSVD   = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_HOLD = 3'b100
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic load;   // capture the incoming request
        logic exec;   // apply the request and register its result
    } t_dp_cmd;

endpackage

[sv/multi_client_watchdog_aggregator_core.sv]
// ----------------------------------------------------------------------------
// multi_client_watchdog_aggregator_core
// Watchdog aggregator over a table of client slots with generation-tagged IDs.
// ----------------------------------------------------------------------------
// Usage:
//   Each request on the s_axis channel is one operation (tuser): tick,
//   register, deregister or client kick, with the client ID in tdata.
//   Every request yields exactly one result on m_axis: status, assigned ID,
//   check_done, kick_device and the current system_ok verdict.
//   The cfg channel writes the check interval (ticks per check), always ready;
//   the user must write it only while no request is outstanding (not enforced).
// Timing:
//   A request is captured in IDLE, executed in EXEC, and the result is
//   valid in HOLD. One request is in flight at a time: a new request is
//   not accepted until the result of the last one is taken, as set by the
//   capture/execute/present sequence of the controller.
// Reset:
//   Synchronous, active low. All slots become vacant with generation 0, the
//   tick count and verdict clear, and the interval returns to 40.
// Stall:
//   The result holds on m_axis until taken; s_axis_tready stays low until then.
// ----------------------------------------------------------------------------
module multi_client_watchdog_aggregator_core #(
    parameter int NUM_CLIENTS = 10,
    parameter int GEN_BITS    = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request: client_id[7:0]
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [mcwd_pkg::IN_W-1:0]     s_axis_tdata,
    // request: mode[1:0]
    input  logic [mcwd_pkg::MODE_W-1:0]   s_axis_tuser,
    // result: status[1:0], assigned_id[9:2], check_done[10], kick_device[11],
    //         system_ok[12], zero[15:13]
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [mcwd_pkg::RES_W-1:0]    m_axis_tdata,
    // check interval write
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [mcwd_pkg::CI_W-1:0]     i_cfg_data
);
    import mcwd_pkg::*;

    t_dp_cmd cmd;

    assign o_cfg_ready = 1'b1;

    mcwd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd)
    );

    mcwd_datapath #(
        .NUM_CLIENTS (NUM_CLIENTS),
        .GEN_BITS    (GEN_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_mode      (s_axis_tuser),
        .i_client_id (s_axis_tdata[ID_W-1:0]),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_result    (m_axis_tdata)
    );

endmodule

[sv/mcwd_ctrl.sv]
// ----------------------------------------------------------------------------
// mcwd_ctrl
// Request sequencer: accept, execute, then hold the result until taken.
// ----------------------------------------------------------------------------
module mcwd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output mcwd_pkg::t_dp_cmd o_cmd
);
    import mcwd_pkg::*;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_HOLD;
            end
            S_HOLD: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_HOLD);
    assign o_cmd.load  = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.exec  = (r_state == S_EXEC);

endmodule

[sv/mcwd_datapath.sv]
// ----------------------------------------------------------------------------
// mcwd_datapath
// Client slot table, tick counter, verdict and result register.
// ----------------------------------------------------------------------------
module mcwd_datapath #(
    parameter int NUM_CLIENTS = 10,
    parameter int GEN_BITS    = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mcwd_pkg::t_dp_cmd             i_cmd,
    input  logic [mcwd_pkg::MODE_W-1:0]   i_mode,
    input  logic [mcwd_pkg::ID_W-1:0]     i_client_id,
    input  logic                          i_cfg_we,
    input  logic [mcwd_pkg::CI_W-1:0]     i_cfg_data,
    output logic [mcwd_pkg::RES_W-1:0]    o_result
);
    import mcwd_pkg::*;

    // Request registers (payload)
    t_mode                 r_mode;
    logic [ID_W-1:0]       r_id;

    // Slot table and check state
    logic [NUM_CLIENTS-1:0] r_used,   n_used;
    logic [NUM_CLIENTS-1:0] r_kicked, n_kicked;
    logic [GEN_BITS-1:0]    r_gen [NUM_CLIENTS];
    logic [GEN_BITS-1:0]    n_gen [NUM_CLIENTS];
    logic [CI_W-1:0]        r_tick, n_tick;
    logic                   r_verdict, n_verdict;
    logic [CI_W-1:0]        r_interval;

    // Result registers (payload)
    t_status               r_status, n_status;
    logic [ID_W-1:0]       r_assigned, n_assigned;
    logic                  r_done, n_done;
    logic                  r_kick, n_kick;

    logic [TAG_BITS-1:0]   slot_tag   [NUM_CLIENTS];
    logic [NUM_CLIENTS-1:0] first_free;
    logic [NUM_CLIENTS-1:0] hit;
    logic                  seen_free;
    logic                  any_free;
    logic                  any_hit;
    logic                  any_used;
    logic                  all_kicked;
    logic [ID_W-1:0]       free_id;
    logic [CI_W-1:0]       limit;
    logic [CI_W:0]         tick_next;
    logic                  expire;

    // Tag view of each generation: low nibble, zero-extended when narrower
    for (genvar g = 0; g < NUM_CLIENTS; g++) begin : g_tag
        logic [GEN_BITS+TAG_BITS-1:0] gen_ext;
        assign gen_ext     = {{TAG_BITS{1'b0}}, r_gen[g]};
        assign slot_tag[g] = gen_ext[TAG_BITS-1:0];
    end

    // Lowest free slot and ID match, all slots in parallel
    always_comb begin
        seen_free = 1'b0;
        free_id   = '0;
        for (int i = 0; i < NUM_CLIENTS; i++) begin
            first_free[i] = !r_used[i] && !seen_free;
            seen_free     = seen_free | !r_used[i];
            if (first_free[i]) begin
                free_id = {slot_tag[i], SLOT_BITS'(i)};
            end
            hit[i] = r_used[i]
                  && (r_id[SLOT_BITS-1:0] == SLOT_BITS'(i))
                  && (slot_tag[i] == r_id[ID_W-1:SLOT_BITS]);
        end
    end

    assign any_free   = |first_free;
    assign any_hit    = |hit;
    assign any_used   = |r_used;
    assign all_kicked = &(r_kicked | ~r_used);

    // A zero interval behaves as one
    assign limit     = (r_interval == '0) ? CI_W'(1) : r_interval;
    assign tick_next = {1'b0, r_tick} + 1'b1;
    assign expire    = (tick_next >= {1'b0, limit});

    always_comb begin
        n_used     = r_used;
        n_kicked   = r_kicked;
        n_gen      = r_gen;
        n_tick     = r_tick;
        n_verdict  = r_verdict;
        n_status   = ST_OK;
        n_assigned = '0;
        n_done     = 1'b0;
        n_kick     = 1'b0;
        unique case (r_mode)
            MODE_TICK: begin
                if (expire) begin
                    // With no clients the previous verdict stands
                    if (any_used) begin
                        n_verdict = all_kicked;
                    end
                    n_kicked = '0;
                    n_tick   = '0;
                    n_done   = 1'b1;
                    n_kick   = any_used ? all_kicked : r_verdict;
                end else begin
                    n_tick = tick_next[CI_W-1:0];
                end
            end
            MODE_REG: begin
                if (any_free) begin
                    n_used     = r_used | first_free;
                    n_kicked   = r_kicked & ~first_free;
                    n_assigned = free_id;
                end else begin
                    n_status = ST_FULL;
                end
            end
            MODE_DEREG: begin
                if (any_hit) begin
                    n_used   = r_used & ~hit;
                    n_kicked = r_kicked & ~hit;
                    for (int i = 0; i < NUM_CLIENTS; i++) begin
                        if (hit[i]) begin
                            n_gen[i] = r_gen[i] + 1'b1;
                        end
                    end
                end else begin
                    n_status = ST_BAD_ID;
                end
            end
            MODE_KICK: begin
                if (any_hit) begin
                    n_kicked = r_kicked | hit;
                end else begin
                    n_status = ST_BAD_ID;
                end
            end
            default: begin
                n_status = ST_BAD_ID;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used     <= '0;
            r_kicked   <= '0;
            r_tick     <= '0;
            r_verdict  <= 1'b0;
            r_interval <= CI_RESET;
            for (int i = 0; i < NUM_CLIENTS; i++) begin
                r_gen[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_interval <= i_cfg_data;
            end
            if (i_cmd.exec) begin
                r_used    <= n_used;
                r_kicked  <= n_kicked;
                r_gen     <= n_gen;
                r_tick    <= n_tick;
                r_verdict <= n_verdict;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= t_mode'(i_mode);
            r_id   <= i_client_id;
        end
        if (i_cmd.exec) begin
            r_status   <= n_status;
            r_assigned <= n_assigned;
            r_done     <= n_done;
            r_kick     <= n_kick;
        end
    end

    // system_ok follows the verdict, updated together with the result
    assign o_result = {(RES_W - RES_BITS)'(0), r_verdict, r_kick, r_done,
                       r_assigned, r_status};

endmodule

[sv/mcwd_checker.sv]
// ----------------------------------------------------------------------------
// mcwd_port_checks
// Port-level checks for the watchdog aggregator, bound to the top level.
// ----------------------------------------------------------------------------
module mcwd_port_checks (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [mcwd_pkg::RES_W-1:0]    m_axis_tdata
);
    import mcwd_pkg::*;

    // One request in flight: no new request while a result is pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("request accepted while a result is pending");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("ready did not drop after accepting a request");

    // Device kick only at the end of a check interval
    a_kick_needs_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[STATUS_W+ID_W+1]) |-> m_axis_tdata[STATUS_W+ID_W])
        else $error("kick_device without check_done");

    // Device kick implies the verdict is ok
    a_kick_means_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[STATUS_W+ID_W+1]) |-> m_axis_tdata[STATUS_W+ID_W+2])
        else $error("kick_device with system_ok low");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind multi_client_watchdog_aggregator_core mcwd_port_checks u_mcwd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
